FILE: rtl/lzwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder dictionary package
// Shared sizes, constants and the command and result types of the decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int DICT_ENTRIES = 4096;
    localparam int ADDR_W       = $clog2(DICT_ENTRIES);
    localparam int NEXT_W       = $clog2(DICT_ENTRIES + 1);
    localparam int CODE_W       = 12;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 12;
    localparam int CMP_W        = (NEXT_W > CODE_W) ? NEXT_W : CODE_W;

    localparam logic [LEN_W-1:0]  LEN_MAX    = '1;
    localparam logic [LEN_W-1:0]  LEN_ONE    = LEN_W'(1);
    localparam logic [NEXT_W-1:0] FIRST_FREE = NEXT_W'(256);
    localparam logic [NEXT_W-1:0] DICT_END   = NEXT_W'(DICT_ENTRIES);

    // Classified code, handed from the front end to the back end.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              start;
        logic              bad;
        logic              missing;
        logic              lookup;
        logic              added;
        logic [ADDR_W-1:0] index;
    } t_cmd;

    // One descriptor as seen on the result ports.
    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [LEN_W-1:0]  length;
        logic              missing;
        logic              added;
        logic [CODE_W-1:0] index;
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] add_byte;
        logic              bad;
    } t_res;

endpackage

FILE: rtl/lzwd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder front end
// Accepts codes, tracks the next free entry and classifies each code.
// ----------------------------------------------------------------------------
module lzwd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [lzwd_pkg::CODE_W-1:0] i_code_in,
    input  logic                       i_stream_start,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output lzwd_pkg::t_cmd             o_cmd
);
    import lzwd_pkg::*;

    logic [NEXT_W-1:0] r_next_free;
    logic [NEXT_W-1:0] n_next_free;
    logic [CMP_W-1:0]  code_ext;
    logic              code_high;
    logic              accept;

    always_comb begin
        accept    = i_push && !i_q_full;
        code_ext  = CMP_W'(i_code_in);
        code_high = code_ext >= CMP_W'(FIRST_FREE);

        o_cmd.code    = i_code_in;
        o_cmd.start   = i_stream_start;
        o_cmd.bad     = i_stream_start && code_high;
        o_cmd.missing = !i_stream_start && (code_ext >= CMP_W'(r_next_free));
        o_cmd.lookup  = !i_stream_start && !o_cmd.missing && code_high;
        o_cmd.added   = !i_stream_start && (r_next_free < DICT_END);
        o_cmd.index   = ADDR_W'(r_next_free);

        n_next_free = r_next_free;
        if (accept) begin
            if (i_stream_start) begin
                n_next_free = FIRST_FREE;
            end else if (o_cmd.added) begin
                n_next_free = r_next_free + 1'b1;
            end
        end
        o_q_push = accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= FIRST_FREE;
        end else begin
            r_next_free <= n_next_free;
        end
    end

endmodule

FILE: rtl/lzwd_cmd_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder command queue
// Two-entry queue of classified codes between the front and back ends.
// ----------------------------------------------------------------------------
module lzwd_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lzwd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output lzwd_pkg::t_cmd o_cmd
);
    import lzwd_pkg::*;

    t_cmd       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        o_full  = r_cnt == 2'd2;
        o_valid = r_cnt != 2'd0;
        o_cmd   = r_q[r_rptr];
        n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/lzwd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder back end
// Reads the dictionary, builds the descriptor, adds entries, queues results.
// ----------------------------------------------------------------------------
module lzwd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  lzwd_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output lzwd_pkg::t_res o_res
);
    import lzwd_pkg::*;

    // Dictionary: first byte and length of each added entry.
    logic [BYTE_W-1:0] r_mem_first [DICT_ENTRIES];
    logic [LEN_W-1:0]  r_mem_len   [DICT_ENTRIES];

    logic              r_s2_valid;
    t_cmd              r_s2_cmd;
    logic [BYTE_W-1:0] r_rd_first;
    logic [LEN_W-1:0]  r_rd_len;

    logic              r_wr_valid;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [BYTE_W-1:0] r_wr_first;
    logic [LEN_W-1:0]  r_wr_len;

    logic [CODE_W-1:0] r_last_code;
    logic [BYTE_W-1:0] r_prev_first;
    logic [LEN_W-1:0]  r_prev_len;
    logic [CODE_W-1:0] n_last_code;
    logic [BYTE_W-1:0] n_prev_first;
    logic [LEN_W-1:0]  n_prev_len;

    t_res              r_oq [2];
    logic              r_oq_wptr;
    logic              r_oq_rptr;
    logic [1:0]        r_oq_cnt;

    logic              s1_take;
    logic              s2_fire;
    logic              oq_pop;
    logic              wr_en;
    logic              fwd_hit;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] lk_first;
    logic [LEN_W-1:0]  lk_len;
    logic [LEN_W-1:0]  new_len;
    t_res              res;

    always_comb begin
        s2_fire   = r_s2_valid && (r_oq_cnt != 2'd2);
        s1_take   = i_cmd_valid && (!r_s2_valid || s2_fire);
        o_cmd_pop = s1_take;
        oq_pop    = i_pop && (r_oq_cnt != 2'd0);
        rd_addr   = ADDR_W'(i_cmd.code);

        // The latest write always holds the newest value of its entry.
        fwd_hit  = r_wr_valid && (r_wr_addr == ADDR_W'(r_s2_cmd.code));
        lk_first = fwd_hit ? r_wr_first : r_rd_first;
        lk_len   = fwd_hit ? r_wr_len : r_rd_len;
        new_len  = (r_prev_len == LEN_MAX) ? LEN_MAX : r_prev_len + 1'b1;

        res          = '0;
        n_last_code  = r_last_code;
        n_prev_first = r_prev_first;
        n_prev_len   = r_prev_len;

        if (r_s2_cmd.start) begin
            res.bad = r_s2_cmd.bad;
            if (r_s2_cmd.bad) begin
                n_last_code  = '0;
                n_prev_first = '0;
            end else begin
                res.first_byte = r_s2_cmd.code[BYTE_W-1:0];
                res.length     = LEN_ONE;
                n_last_code    = r_s2_cmd.code;
                n_prev_first   = r_s2_cmd.code[BYTE_W-1:0];
            end
            n_prev_len = LEN_ONE;
        end else begin
            res.missing = r_s2_cmd.missing;
            if (r_s2_cmd.missing) begin
                res.first_byte = r_prev_first;
                res.length     = new_len;
            end else if (r_s2_cmd.lookup) begin
                res.first_byte = lk_first;
                res.length     = lk_len;
            end else begin
                res.first_byte = r_s2_cmd.code[BYTE_W-1:0];
                res.length     = LEN_ONE;
            end

            if (r_s2_cmd.added) begin
                res.added    = 1'b1;
                res.index    = CODE_W'(r_s2_cmd.index);
                res.prefix   = r_last_code;
                res.add_byte = res.first_byte;
                n_last_code  = r_s2_cmd.missing ? CODE_W'(r_s2_cmd.index) : r_s2_cmd.code;
                n_prev_first = res.first_byte;
                n_prev_len   = res.length;
            end else if (!r_s2_cmd.missing) begin
                n_last_code  = r_s2_cmd.code;
                n_prev_first = res.first_byte;
                n_prev_len   = res.length;
            end
        end

        wr_en   = s2_fire && r_s2_cmd.added;
        o_empty = r_oq_cnt == 2'd0;
        o_res   = r_oq[r_oq_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_rd_first <= r_mem_first[rd_addr];
            r_rd_len   <= r_mem_len[rd_addr];
        end
        if (wr_en) begin
            r_mem_first[r_s2_cmd.index] <= r_prev_first;
            r_mem_len[r_s2_cmd.index]   <= new_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid   <= 1'b0;
            r_wr_valid   <= 1'b0;
            r_last_code  <= '0;
            r_prev_first <= '0;
            r_prev_len   <= LEN_ONE;
            r_oq_wptr    <= 1'b0;
            r_oq_rptr    <= 1'b0;
            r_oq_cnt     <= 2'd0;
        end else begin
            if (s1_take) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (wr_en) begin
                r_wr_valid <= 1'b1;
            end
            if (s2_fire) begin
                r_last_code  <= n_last_code;
                r_prev_first <= n_prev_first;
                r_prev_len   <= n_prev_len;
                r_oq_wptr    <= ~r_oq_wptr;
            end
            if (oq_pop) begin
                r_oq_rptr <= ~r_oq_rptr;
            end
            r_oq_cnt <= r_oq_cnt + {1'b0, s2_fire} - {1'b0, oq_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_s2_cmd <= i_cmd;
        end
        if (wr_en) begin
            r_wr_addr  <= r_s2_cmd.index;
            r_wr_first <= r_prev_first;
            r_wr_len   <= new_len;
        end
        if (s2_fire) begin
            r_oq[r_oq_wptr] <= res;
        end
    end

endmodule

FILE: rtl/lzw_decode_dictionary_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder dictionary builder
// Keeps the 12-bit LZW decoder dictionary and gives one descriptor per code.
// ----------------------------------------------------------------------------
// Usage:
// Codes enter through a queue-like port: an item is taken at a clock edge with
// push high and full low. Descriptors leave the same way: while empty is low
// the oldest descriptor is on the result ports, and pop takes it.
// Each code yields exactly one descriptor, in order.
// Throughput is one item per cycle while pop keeps up. A code is taken into
// a two-entry command queue, then read from the dictionary RAM into the back
// end's stage register, and its descriptor is then written into a two-entry
// result queue, whereupon empty drops. The single RAM read and write per
// cycle set the rate; an entry written by the item just ahead is forwarded.
// When pop stays low the result queue fills, the back end holds its item,
// the command queue fills and full rises; nothing is lost.
// Reset empties both queues, sets the next free entry to 256 and the
// previous code to 0. Dictionary contents are not cleared: every entry is
// written within a stream before it is read.
// ----------------------------------------------------------------------------
module lzw_decode_dictionary_builder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [lzwd_pkg::CODE_W-1:0] i_code_in,
    input  logic                        i_stream_start,
    output logic                        empty,
    input  logic                        pop,
    output logic [lzwd_pkg::BYTE_W-1:0] o_decoded_first_byte,
    output logic [lzwd_pkg::LEN_W-1:0]  o_decoded_length,
    output logic                        o_code_was_missing,
    output logic                        o_entry_added,
    output logic [lzwd_pkg::CODE_W-1:0] o_added_index,
    output logic [lzwd_pkg::CODE_W-1:0] o_added_prefix,
    output logic [lzwd_pkg::BYTE_W-1:0] o_added_byte,
    output logic                        o_bad_first_code
);
    import lzwd_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    t_res res;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    lzwd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_code_in      (i_code_in),
        .i_stream_start (i_stream_start),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_cmd          (front_cmd)
    );

    lzwd_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    lzwd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign full                 = q_full;
    assign o_decoded_first_byte = res.first_byte;
    assign o_decoded_length     = res.length;
    assign o_code_was_missing   = res.missing;
    assign o_entry_added        = res.added;
    assign o_added_index        = res.index;
    assign o_added_prefix       = res.prefix;
    assign o_added_byte         = res.add_byte;
    assign o_bad_first_code     = res.bad;

endmodule

FILE: rtl/lzwd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW decoder port checker
// Watches the top-level ports and flags descriptors or timing that cannot occur.
// ----------------------------------------------------------------------------
module lzwd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [lzwd_pkg::BYTE_W-1:0] o_decoded_first_byte,
    input logic [lzwd_pkg::LEN_W-1:0]  o_decoded_length,
    input logic                        o_code_was_missing,
    input logic                        o_entry_added,
    input logic [lzwd_pkg::CODE_W-1:0] o_added_index,
    input logic [lzwd_pkg::CODE_W-1:0] o_added_prefix,
    input logic [lzwd_pkg::BYTE_W-1:0] o_added_byte,
    input logic                        o_bad_first_code
);
    import lzwd_pkg::*;

    // Reset leaves both queues empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // A waiting descriptor holds while it is not taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> ($stable(o_decoded_length) && $stable(o_added_index)
                              && $stable(o_decoded_first_byte)))
        else $error("descriptor changed while stalled");

    // Without an added entry the entry fields read as zero.
    a_no_add_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_entry_added) |->
            (o_added_index == '0 && o_added_prefix == '0 && o_added_byte == '0))
        else $error("entry fields set without an added entry");

    // A bad first code decodes to nothing and adds nothing.
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_bad_first_code) |->
            (o_decoded_length == '0 && !o_entry_added && !o_code_was_missing))
        else $error("bad first code with decoded content");

    // Every other code decodes to at least one byte.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_bad_first_code) |-> (o_decoded_length != '0))
        else $error("zero length for a good code");

endmodule

bind lzw_decode_dictionary_builder_core lzwd_checker u_lzwd_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW dictionary builder testbench
// Feeds 12-bit LZW codes through the push/full port and checks every
// descriptor popped from the result port against a dictionary tracked here.
// Covers decoding without a stream start, stream boundaries, bad first
// codes, undefined codes and random streams.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_PCT    = 37;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;
    localparam int RANDOM_ITEMS = 1880;
    localparam int CODE_W      = lzwd_pkg::CODE_W;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    logic [lzwd_pkg::CODE_W-1:0] i_code_in = '0;
    logic                        i_stream_start = 1'b0;
    logic                        empty;
    logic                        pop = 1'b0;
    logic [lzwd_pkg::BYTE_W-1:0] o_decoded_first_byte;
    logic [lzwd_pkg::LEN_W-1:0]  o_decoded_length;
    logic                        o_code_was_missing;
    logic                        o_entry_added;
    logic [lzwd_pkg::CODE_W-1:0] o_added_index;
    logic [lzwd_pkg::CODE_W-1:0] o_added_prefix;
    logic [lzwd_pkg::BYTE_W-1:0] o_added_byte;
    logic                        o_bad_first_code;

    lzw_decode_dictionary_builder_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .push                 (push),
        .full                 (full),
        .i_code_in            (i_code_in),
        .i_stream_start       (i_stream_start),
        .empty                (empty),
        .pop                  (pop),
        .o_decoded_first_byte (o_decoded_first_byte),
        .o_decoded_length     (o_decoded_length),
        .o_code_was_missing   (o_code_was_missing),
        .o_entry_added        (o_entry_added),
        .o_added_index        (o_added_index),
        .o_added_prefix       (o_added_prefix),
        .o_added_byte         (o_added_byte),
        .o_bad_first_code     (o_bad_first_code)
    );

    // Dictionary as the decoder should see it; only first byte and length
    // of each entry matter for the descriptors.
    logic [lzwd_pkg::BYTE_W-1:0] dict_first_byte [lzwd_pkg::DICT_ENTRIES];
    logic [lzwd_pkg::LEN_W-1:0]  dict_length     [lzwd_pkg::DICT_ENTRIES];
    logic [lzwd_pkg::CODE_W-1:0] last_code  = '0;
    logic [lzwd_pkg::NEXT_W-1:0] next_entry = lzwd_pkg::FIRST_FREE;

    lzwd_pkg::t_res expected_descriptors[$];

    logic idle_on = 1'b1;
    int   mismatch_count   = 0;
    int   unexpected_count = 0;
    int   stall_cycles     = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // First byte and length of a defined code, packed as {first, length}.
    function automatic logic [lzwd_pkg::BYTE_W+lzwd_pkg::LEN_W-1:0]
            entry_info(input logic [lzwd_pkg::CODE_W-1:0] code);
        if (code < lzwd_pkg::FIRST_FREE) begin
            return {code[lzwd_pkg::BYTE_W-1:0], lzwd_pkg::LEN_ONE};
        end
        return {dict_first_byte[code], dict_length[code]};
    endfunction

    // Decodes one code against the tracked dictionary and updates it.
    function automatic lzwd_pkg::t_res decode_descriptor(
            input logic [lzwd_pkg::CODE_W-1:0] code, input logic start);
        lzwd_pkg::t_res              d;
        logic [lzwd_pkg::BYTE_W-1:0] p_first;
        logic [lzwd_pkg::LEN_W-1:0]  p_len;
        logic [lzwd_pkg::LEN_W-1:0]  grown;
        d = '0;
        if (start) begin
            next_entry = lzwd_pkg::FIRST_FREE;
            if (code < lzwd_pkg::FIRST_FREE) begin
                d.first_byte = code[lzwd_pkg::BYTE_W-1:0];
                d.length     = lzwd_pkg::LEN_ONE;
                last_code    = code;
            end else begin
                d.bad     = 1'b1;
                last_code = '0;
            end
        end else begin
            {p_first, p_len} = entry_info(last_code);
            grown = (p_len == lzwd_pkg::LEN_MAX) ? lzwd_pkg::LEN_MAX : p_len + 1'b1;
            if (code < next_entry) begin
                {d.first_byte, d.length} = entry_info(code);
            end else begin
                // Not yet defined: previous string plus its own first byte.
                d.missing    = 1'b1;
                d.first_byte = p_first;
                d.length     = grown;
            end
            if (next_entry < lzwd_pkg::DICT_END) begin
                d.added    = 1'b1;
                d.index    = next_entry[lzwd_pkg::CODE_W-1:0];
                d.prefix   = last_code;
                d.add_byte = d.first_byte;
                dict_first_byte[next_entry[lzwd_pkg::CODE_W-1:0]] = p_first;
                dict_length[next_entry[lzwd_pkg::CODE_W-1:0]]     = grown;
                last_code  = d.missing ? next_entry[lzwd_pkg::CODE_W-1:0] : code;
                next_entry = next_entry + 1'b1;
            end else if (!d.missing) begin
                last_code = code;
            end
        end
        return d;
    endfunction

    function automatic string describe(input lzwd_pkg::t_res r);
        return $sformatf("first=%h len=%0d miss=%b add=%b idx=%0d pre=%0d byte=%h bad=%b",
                         r.first_byte, r.length, r.missing, r.added, r.index,
                         r.prefix, r.add_byte, r.bad);
    endfunction

    // Picks a code that is mostly well formed for the current dictionary.
    function automatic logic [lzwd_pkg::CODE_W-1:0] pick_code();
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = int'(next_entry) - 1;
        if (roll < 5) begin
            return CODE_W'($urandom_range(0, 4095));
        end else if (roll < 25 && next_entry < lzwd_pkg::DICT_END) begin
            return next_entry[lzwd_pkg::CODE_W-1:0];
        end else if (roll < 50) begin
            return CODE_W'($urandom_range(0, 255));
        end else if (roll < 70 && top >= 256) begin
            return CODE_W'($urandom_range((top - 8 > 256) ? top - 8 : 256, top));
        end
        return CODE_W'($urandom_range(0, top));
    endfunction

    task automatic send_code(input logic [lzwd_pkg::CODE_W-1:0] code, input logic start);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push           <= 1'b1;
        i_code_in      <= code;
        i_stream_start <= start;
        @(posedge i_clk);
        while (full !== 1'b0) begin
            @(posedge i_clk);
        end
        expected_descriptors.push_back(decode_descriptor(code, start));
    endtask

    // Holds the sender back until every outstanding descriptor has been popped.
    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (expected_descriptors.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_no_start_after_reset();
        send_code(12'd65, 1'b0);
        send_code(12'd256, 1'b0);
        send_code(12'd300, 1'b0);
        send_code(12'd4095, 1'b0);
        drain_results();
    endtask

    task automatic test_stream_boundaries();
        send_code(12'd0, 1'b1);
        send_code(12'd255, 1'b0);
        send_code(12'd257, 1'b0);
        send_code(12'd258, 1'b0);
        send_code(12'd255, 1'b1);
        send_code(12'd256, 1'b1);
        send_code(12'd4095, 1'b0);
        send_code(12'd4095, 1'b1);
        send_code(12'd2048, 1'b0);
        send_code(12'd7, 1'b1);
        send_code(12'd256, 1'b0);
        send_code(12'd0, 1'b0);
        send_code(12'd258, 1'b0);
        send_code(12'd1, 1'b1);
        send_code(12'd0, 1'b0);
        drain_results();
    endtask

    task automatic test_random_streams();
        int sent;
        int stream_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = !(sent >= 700 && sent < 1000);
            if ($urandom_range(0, 9) == 0) begin
                send_code(CODE_W'($urandom_range(256, 4095)), 1'b1);
            end else begin
                send_code(CODE_W'($urandom_range(0, 255)), 1'b1);
            end
            sent++;
            stream_len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 800)
                                                     : $urandom_range(1, 120);
            if (stream_len > RANDOM_ITEMS - sent) begin
                stream_len = RANDOM_ITEMS - sent;
            end
            repeat (stream_len) begin
                idle_on = !(sent >= 700 && sent < 1000);
                if ($urandom_range(0, 49) == 0) begin
                    send_code(CODE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
                end else begin
                    send_code(pick_code(), 1'b0);
                end
                sent++;
            end
            if ($urandom_range(0, 4) == 0) begin
                drain_results();
            end
        end
        idle_on = 1'b1;
        drain_results();
    endtask

    always @(negedge i_clk) begin
        pop <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        lzwd_pkg::t_res got;
        lzwd_pkg::t_res want;
        if (i_rst_n && pop && empty === 1'b0) begin
            got.first_byte = o_decoded_first_byte;
            got.length     = o_decoded_length;
            got.missing    = o_code_was_missing;
            got.added      = o_entry_added;
            got.index      = o_added_index;
            got.prefix     = o_added_prefix;
            got.add_byte   = o_added_byte;
            got.bad        = o_bad_first_code;
            if (expected_descriptors.size() == 0) begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10) begin
                    $display("unexpected item: %s", describe(got));
                end
            end else begin
                want = expected_descriptors.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10) begin
                        $display("mismatch at %0t: expected %s", $realtime, describe(want));
                        $display("                   actual   %s", describe(got));
                    end
                end
            end
        end
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_no_start_after_reset();
        test_stream_boundaries();
        test_random_streams();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_descriptors.size() == 0)
        begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lzwd_pkg.sv
rtl/lzwd_front.sv
rtl/lzwd_cmd_q.sv
rtl/lzwd_back.sv
rtl/lzw_decode_dictionary_builder_core.sv
rtl/lzwd_checker.sv
tb/sv/tb.sv
